[src/iecr_pkg.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply checker package
// Shared item types, status codes and the expected echo payload text.
// ----------------------------------------------------------------------------
package iecr_pkg;

    localparam int PosW         = 8;
    localparam int PayloadStart = 8;
    localparam int PayloadLen   = 11;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_CSUM    = 3'd1;
    localparam logic [2:0] ST_NOT_REPLY   = 3'd2;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd3;
    localparam logic [2:0] ST_PAYLOAD     = 3'd4;

    localparam logic [0:0] CFG_IDENT    = 1'd0;
    localparam logic [0:0] CFG_SEQUENCE = 1'd1;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  ttl_seen;
        logic [7:0]  icmp_length;
        logic [15:0] ident_seen;
        logic [15:0] sequence_seen;
    } t_out_item;

    typedef struct packed {
        logic [15:0] sum;
        logic [7:0]  icmp_len;
        logic        type_bad;
        logic        payload_bad;
        logic [7:0]  ttl;
        logic [15:0] ident;
        logic [15:0] seq_num;
    } t_dgram_view;

    function automatic logic [7:0] echo_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h6c;
            4'd3:    c = 8'h6c;
            4'd4:    c = 8'h6f;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h57;
            4'd7:    c = 8'h6f;
            4'd8:    c = 8'h72;
            4'd9:    c = 8'h6c;
            4'd10:   c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/iecr_datagram.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply checker datagram tracker
// Holds the per-datagram state and folds one byte into it per step.
// ----------------------------------------------------------------------------
module iecr_datagram import iecr_pkg::*; #(
    parameter int MAX_LEN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    output t_dgram_view o_view
);

    localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);

    logic [PosW-1:0] r_pos, n_pos;
    logic [5:0]      r_hdr, n_hdr;
    logic [7:0]      r_ttl, n_ttl;
    logic [15:0]     r_sum, n_sum;
    logic [7:0]      r_high, n_high;
    logic [15:0]     r_ident, n_ident;
    logic [15:0]     r_seq, n_seq;
    logic            r_type_bad, n_type_bad;
    logic            r_pay_bad, n_pay_bad;

    logic [7:0]      b;
    logic [5:0]      hdr_now;
    logic [PosW-1:0] k;
    logic [PosW-1:0] pay_off;
    logic [PosW-1:0] icmp_len;
    logic            word_en;
    logic [15:0]     word;
    logic [16:0]     wide_sum;

    always_comb begin
        b          = i_item.packet_byte;
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_ttl      = r_ttl;
        n_high     = r_high;
        n_ident    = r_ident;
        n_seq      = r_seq;
        n_type_bad = r_type_bad;
        n_pay_bad  = r_pay_bad;
        word_en    = 1'b0;
        word       = '0;
        hdr_now    = (r_pos == '0) ? {b[3:0], 2'b00} : r_hdr;
        k          = r_pos - {2'b00, hdr_now};
        pay_off    = k - PosW'(PayloadStart);

        if (r_pos < MaxPos) begin
            n_hdr = hdr_now;
            if (r_pos == PosW'(8)) begin
                n_ttl = b;
            end
            if (r_pos >= {2'b00, hdr_now}) begin
                if (!k[0]) begin
                    n_high = b;
                end else begin
                    word_en = 1'b1;
                    word    = {r_high, b};
                end
                if ((k == PosW'(0) || k == PosW'(1)) && b != 8'h00) begin
                    n_type_bad = 1'b1;
                end else if (k == PosW'(4)) begin
                    n_ident[15:8] = b;
                end else if (k == PosW'(5)) begin
                    n_ident[7:0] = b;
                end else if (k == PosW'(6)) begin
                    n_seq[15:8] = b;
                end else if (k == PosW'(7)) begin
                    n_seq[7:0] = b;
                end else if (k >= PosW'(PayloadStart)
                             && k < PosW'(PayloadStart + PayloadLen)) begin
                    if (b != echo_char(pay_off[3:0])) begin
                        n_pay_bad = 1'b1;
                    end
                end else if (k == PosW'(PayloadStart + PayloadLen) && b != 8'h00) begin
                    n_pay_bad = 1'b1;
                end
            end
            n_pos = r_pos + PosW'(1);
        end

        icmp_len = (n_pos > {2'b00, n_hdr}) ? n_pos - {2'b00, n_hdr} : '0;
        if (i_item.last_byte && icmp_len[0]) begin
            word_en = 1'b1;
            word    = {n_high, 8'h00};
        end

        wide_sum = {1'b0, r_sum} + {1'b0, word};
        if (!word_en) begin
            n_sum = r_sum;
        end else if (wide_sum[16]) begin
            n_sum = wide_sum[15:0] + 16'd1;
        end else begin
            n_sum = wide_sum[15:0];
        end
    end

    always_comb begin
        o_view.sum         = n_sum;
        o_view.icmp_len    = icmp_len;
        o_view.type_bad    = n_type_bad;
        o_view.payload_bad = n_pay_bad;
        o_view.ttl         = n_ttl;
        o_view.ident       = n_ident;
        o_view.seq_num     = n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_pos      <= '0;
            r_hdr      <= '0;
            r_ttl      <= '0;
            r_sum      <= 16'hffff;
            r_high     <= '0;
            r_ident    <= '0;
            r_seq      <= '0;
            r_type_bad <= 1'b0;
            r_pay_bad  <= 1'b0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_hdr      <= n_hdr;
            r_ttl      <= n_ttl;
            r_sum      <= n_sum;
            r_high     <= n_high;
            r_ident    <= n_ident;
            r_seq      <= n_seq;
            r_type_bad <= n_type_bad;
            r_pay_bad  <= n_pay_bad;
        end
    end

endmodule

[src/iecr_verdict.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply checker verdict
// Ranks the checks of a finished datagram into one status code.
// ----------------------------------------------------------------------------
module iecr_verdict import iecr_pkg::*; (
    input  t_dgram_view i_view,
    input  logic [15:0] i_expected_ident,
    input  logic [15:0] i_expected_sequence,
    output t_out_item   o_result
);

    always_comb begin
        priority if (i_view.sum != 16'hffff) begin
            o_result.status = ST_BAD_CSUM;
        end else if (i_view.icmp_len < 8'd2 || i_view.type_bad) begin
            o_result.status = ST_NOT_REPLY;
        end else if (i_view.icmp_len < 8'(PayloadStart)
                     || i_view.ident != i_expected_ident
                     || i_view.seq_num != i_expected_sequence) begin
            o_result.status = ST_ID_MISMATCH;
        end else if (i_view.icmp_len < 8'(PayloadStart + PayloadLen)
                     || i_view.payload_bad) begin
            o_result.status = ST_PAYLOAD;
        end else begin
            o_result.status = ST_OK;
        end
        o_result.ttl_seen      = i_view.ttl;
        o_result.icmp_length   = i_view.icmp_len;
        o_result.ident_seen    = i_view.ident;
        o_result.sequence_seen = i_view.seq_num;
    end

endmodule

[src/icmp_echo_reply_checker.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Checks a byte-serial IPv4 datagram as a valid ICMP echo reply.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_ready    t_in_item
//   out      output     o_out_valid / i_out_ready  t_out_item
//   cfg      input      i_cfg_valid / o_cfg_ready  index + 16-bit data
//
// One byte is taken every cycle while no final byte is stalled; the last byte
// passes through the input register and then the result register.
// A final byte waits in the input register while an earlier result is
// still held, which stalls the input for as long as the output stalls.
// Reset clears all datagram state, the expected ident and sequence, and the valid flags of both registers.
// ----------------------------------------------------------------------------
module icmp_echo_reply_checker import iecr_pkg::*; #(
    parameter int MAX_LEN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_exp_ident;
    logic [15:0] r_exp_seq;

    logic        advance;
    t_dgram_view view;
    t_out_item   result;

    assign advance     = r_in_valid && (!r_in_item.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    iecr_datagram #(
        .MAX_LEN(MAX_LEN)
    ) u_datagram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (advance),
        .i_item (r_in_item),
        .o_view (view)
    );

    iecr_verdict u_verdict (
        .i_view             (view),
        .i_expected_ident   (r_exp_ident),
        .i_expected_sequence(r_exp_seq),
        .o_result           (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ident <= '0;
            r_exp_seq   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDENT:    r_exp_ident <= i_cfg_data;
                CFG_SEQUENCE: r_exp_seq   <= i_cfg_data;
                default:      r_exp_ident <= r_exp_ident;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.last_byte) begin
            r_out_item <= result;
        end
    end

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_item.last_byte))
        else $error("result appeared without a final byte");

    a_stalled_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("stalled byte lost from the input register");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.status <= ST_PAYLOAD))
        else $error("status code out of range");

endmodule

[tb/sv/icmp_echo_reply_checker_tb.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply checker testbench
// Streams IPv4 datagrams into the checker one byte word at a time under random
// idling and receiver back-pressure. The bench keeps its own copy of the
// checksum, header and payload checks and compares every reply word field by
// field against the oldest expected verdict.
// ----------------------------------------------------------------------------
module icmp_echo_reply_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iecr_pkg::*;

    localparam int          MAX_LEN         = 128;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam logic [87:0] ECHO_TEXT       = "Hello World";

    typedef enum int {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_TYPE,
        FLAW_TEXT,
        FLAW_SHORT
    } reply_flaw_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_IDENT;
    logic [15:0] cfg_data = 16'h0000;

    logic [15:0] ident_reg = 16'h0000;
    logic [15:0] sequence_reg = 16'h0000;

    int unsigned dg_pos = 0;
    int unsigned dg_hdr = 0;
    logic [7:0]  dg_ttl = 8'h00;
    logic [7:0]  dg_high = 8'h00;
    logic [15:0] dg_sum = 16'hffff;
    logic [15:0] dg_ident = 16'h0000;
    logic [15:0] dg_seq = 16'h0000;
    logic        dg_type_bad = 1'b0;
    logic        dg_text_bad = 1'b0;

    t_out_item   expected_replies[$];
    t_out_item   reply_want;
    logic [7:0]  dgram[$];

    int          error_count = 0;
    int          bytes_sent = 0;
    int          stall_cycles = 0;
    int          rx_hold_cycles = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    icmp_echo_reply_checker #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] total;
        total = {1'b0, acc} + {1'b0, word};
        if (total > 17'h0ffff) begin
            total = total - 17'h0ffff;
        end
        return total[15:0];
    endfunction

    function automatic logic [7:0] echo_byte(input int k);
        return ECHO_TEXT[8 * (10 - k) +: 8];
    endfunction

    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic clear_datagram_state();
        dg_pos = 0;
        dg_hdr = 0;
        dg_ttl = 8'h00;
        dg_high = 8'h00;
        dg_sum = 16'hffff;
        dg_ident = 16'h0000;
        dg_seq = 16'h0000;
        dg_type_bad = 1'b0;
        dg_text_bad = 1'b0;
    endtask

    task automatic predict_reply_byte(input logic [7:0] b, input logic last);
        int unsigned k;
        int unsigned len;
        t_out_item   reply;
        if (dg_pos < MAX_LEN) begin
            if (dg_pos == 0) begin
                dg_hdr = 4 * int'(b[3:0]);
            end
            if (dg_pos == 8) begin
                dg_ttl = b;
            end
            if (dg_pos >= dg_hdr) begin
                k = dg_pos - dg_hdr;
                if (k[0] == 1'b0) begin
                    dg_high = b;
                end else begin
                    dg_sum = ones_add(dg_sum, {dg_high, b});
                end
                if (k < 2) begin
                    if (b != 8'h00) begin
                        dg_type_bad = 1'b1;
                    end
                end else if (k == 4) begin
                    dg_ident[15:8] = b;
                end else if (k == 5) begin
                    dg_ident[7:0] = b;
                end else if (k == 6) begin
                    dg_seq[15:8] = b;
                end else if (k == 7) begin
                    dg_seq[7:0] = b;
                end else if (k >= PayloadStart && k < PayloadStart + PayloadLen) begin
                    if (b != echo_byte(k - PayloadStart)) begin
                        dg_text_bad = 1'b1;
                    end
                end else if (k == PayloadStart + PayloadLen && b != 8'h00) begin
                    dg_text_bad = 1'b1;
                end
            end
            dg_pos++;
        end
        if (last) begin
            len = (dg_pos > dg_hdr) ? dg_pos - dg_hdr : 0;
            if (len[0]) begin
                dg_sum = ones_add(dg_sum, {dg_high, 8'h00});
            end
            if (dg_sum != 16'hffff) begin
                reply.status = ST_BAD_CSUM;
            end else if (len < 2 || dg_type_bad) begin
                reply.status = ST_NOT_REPLY;
            end else if (len < PayloadStart || dg_ident != ident_reg ||
                         dg_seq != sequence_reg) begin
                reply.status = ST_ID_MISMATCH;
            end else if (len < PayloadStart + PayloadLen || dg_text_bad) begin
                reply.status = ST_PAYLOAD;
            end else begin
                reply.status = ST_OK;
            end
            reply.ttl_seen = dg_ttl;
            reply.icmp_length = len[7:0];
            reply.ident_seen = dg_ident;
            reply.sequence_seen = dg_seq;
            expected_replies.push_back(reply);
            clear_datagram_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= {value, last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_reply_byte(value, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++) begin
            send_byte(dgram[i], i == dgram.size() - 1);
        end
    endtask

    task automatic await_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_replies.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [15:0] ident, input logic [15:0] seq);
        await_replies();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDENT;
        cfg_data <= ident;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        ident_reg = ident;
        @(negedge clk);
        cfg_index <= CFG_SEQUENCE;
        cfg_data <= seq;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sequence_reg = seq;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_noise(input int len);
        dgram.delete();
        repeat (len) dgram.push_back(8'($urandom));
    endtask

    task automatic build_reply(input int ihl, input logic [15:0] ident,
                               input logic [15:0] seq, input int tail_len,
                               input reply_flaw_e flaw);
        logic [7:0]  icmp[$];
        logic [15:0] sum;
        int          keep;
        int          span;
        int          pick;
        dgram.delete();
        for (int p = 0; p < 4 * ihl; p++) begin
            dgram.push_back(8'($urandom));
        end
        if (ihl > 0) begin
            dgram[0] = {4'h4, 4'(ihl)};
        end
        repeat (4) icmp.push_back(8'h00);
        icmp.push_back(ident[15:8]);
        icmp.push_back(ident[7:0]);
        icmp.push_back(seq[15:8]);
        icmp.push_back(seq[7:0]);
        for (int k = 0; k < PayloadLen; k++) begin
            icmp.push_back(echo_byte(k));
        end
        if (tail_len > 0) begin
            icmp.push_back(8'h00);
        end
        for (int k = 1; k < tail_len; k++) begin
            icmp.push_back(8'($urandom));
        end
        keep = icmp.size();
        case (flaw)
            FLAW_TYPE: begin
                icmp[$urandom_range(0, 1)] = 8'($urandom_range(1, 255));
            end
            FLAW_TEXT: begin
                if (tail_len > 0) begin
                    pick = $urandom_range(PayloadStart, PayloadStart + PayloadLen);
                end else begin
                    pick = $urandom_range(PayloadStart, PayloadStart + PayloadLen - 1);
                end
                icmp[pick] = icmp[pick] ^ 8'($urandom_range(1, 255));
            end
            FLAW_SHORT: begin
                keep = $urandom_range(0, PayloadStart + PayloadLen - 1);
            end
            default: begin
            end
        endcase
        span = (keep < MAX_LEN - 4 * ihl) ? keep : MAX_LEN - 4 * ihl;
        if (span >= 4) begin
            sum = 16'h0000;
            for (int k = 0; k < span; k += 2) begin
                sum = ones_add(sum, {icmp[k], (k + 1 < span) ? icmp[k + 1] : 8'h00});
            end
            sum = ~sum;
            icmp[2] = sum[15:8];
            icmp[3] = sum[7:0];
        end
        if (flaw == FLAW_CSUM && span > 0) begin
            pick = $urandom_range(0, span - 1);
            icmp[pick] = icmp[pick] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < keep; k++) begin
            dgram.push_back(icmp[k]);
        end
    endtask

    task automatic send_random_datagram();
        int          pick;
        int          ihl;
        int          tail;
        logic [15:0] id;
        logic [15:0] sq;
        pick = $urandom_range(0, 99);
        ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
        tail = ($urandom_range(0, 19) == 0) ? $urandom_range(90, 200) : $urandom_range(0, 6);
        id = ($urandom_range(0, 6) == 0) ? 16'($urandom) : ident_reg;
        sq = ($urandom_range(0, 6) == 0) ? 16'($urandom) : sequence_reg;
        if (pick < 10) begin
            build_noise($urandom_range(1, 40));
        end else if (pick < 55) begin
            build_reply(ihl, id, sq, tail, FLAW_NONE);
        end else if (pick < 67) begin
            build_reply(ihl, id, sq, tail, FLAW_CSUM);
        end else if (pick < 77) begin
            build_reply(ihl, id, sq, tail, FLAW_TYPE);
        end else if (pick < 88) begin
            build_reply(ihl, id, sq, tail, FLAW_TEXT);
        end else begin
            build_reply(ihl, id, sq, tail, FLAW_SHORT);
        end
        send_datagram();
    endtask

    task automatic test_directed_cases();
        write_config(16'h0000, 16'h0000);
        // With a header length of zero the type byte is also byte 0 of the datagram.
        build_reply(0, 16'h0000, 16'h0000, 0, FLAW_NONE);
        send_datagram();
        build_noise(1);
        dgram[0] = 8'h45;
        send_datagram();
        build_noise(3);
        dgram[0] = 8'h00;
        dgram[1] = 8'h00;
        dgram[2] = 8'h00;
        send_datagram();
        dgram[2] = 8'hff;
        send_datagram();
        build_noise(2);
        dgram[0] = 8'hff;
        dgram[1] = 8'hff;
        send_datagram();
    endtask

    task automatic test_config_extremes();
        write_config(16'hffff, 16'hffff);
        build_reply(5, 16'hffff, 16'hffff, 0, FLAW_NONE);
        send_datagram();
        build_reply(5, 16'h0000, 16'hffff, 1, FLAW_NONE);
        send_datagram();
        write_config(16'h0000, 16'hffff);
        build_reply(5, 16'h0000, 16'hffff, 3, FLAW_NONE);
        send_datagram();
    endtask

    task automatic test_long_datagrams();
        write_config(16'($urandom), 16'($urandom));
        build_reply(5, ident_reg, sequence_reg, 120, FLAW_NONE);
        send_datagram();
        build_reply(15, ident_reg, sequence_reg, 200, FLAW_NONE);
        send_datagram();
    endtask

    task automatic test_stalled_receiver();
        await_replies();
        tx_calm = 1'b1;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (12) begin
            build_reply(0, ident_reg, sequence_reg, 0, FLAW_NONE);
            send_datagram();
        end
        await_replies();
        tx_calm = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_config(16'h0000, 16'hffff);
                2: write_config(16'hffff, 16'h0000);
                default: write_config(16'($urandom), 16'($urandom));
            endcase
            start = bytes_sent;
            while (bytes_sent - start < target / 4) begin
                if ($urandom_range(0, 9) == 0) begin
                    write_config(ident_reg, 16'($urandom));
                end
                tx_calm = ($urandom_range(0, 3) == 0);
                send_random_datagram();
            end
        end
    endtask

    initial begin : reply_sink
        int gap;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                rx_calm = !rx_calm;
            end
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = draw_gap(rx_calm);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic report_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: reply word 0x%h arrived with none expected", $time, out_item);
                error_count++;
            end else begin
                reply_want = expected_replies.pop_front();
                if (out_item.status !== reply_want.status) begin
                    report_field("status", 16'(reply_want.status), 16'(out_item.status));
                end
                if (out_item.ttl_seen !== reply_want.ttl_seen) begin
                    report_field("ttl_seen", 16'(reply_want.ttl_seen),
                                 16'(out_item.ttl_seen));
                end
                if (out_item.icmp_length !== reply_want.icmp_length) begin
                    report_field("icmp_length", 16'(reply_want.icmp_length),
                                 16'(out_item.icmp_length));
                end
                if (out_item.ident_seen !== reply_want.ident_seen) begin
                    report_field("ident_seen", reply_want.ident_seen, out_item.ident_seen);
                end
                if (out_item.sequence_seen !== reply_want.sequence_seen) begin
                    report_field("sequence_seen", reply_want.sequence_seen,
                                 out_item.sequence_seen);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
                $display("icmp_echo_reply_checker_tb failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_config_extremes();
        test_long_datagrams();
        test_stalled_receiver();
        test_random_traffic(1000);
        await_replies();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("icmp_echo_reply_checker_tb passed");
        end else begin
            $display("icmp_echo_reply_checker_tb failed");
        end
        $finish;
    end

endmodule
